FILE: rtl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared widths, types and the cofactor operand table of the 3x3 inverter.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int DATA_W = 32;   // matrix entry
    localparam int PROD_W = 64;   // entry times entry
    localparam int COF_W  = 65;   // signed cofactor
    localparam int CMAG_W = 64;   // cofactor magnitude
    localparam int DET_W  = 98;   // signed determinant
    localparam int DMAG_W = 96;   // determinant magnitude
    localparam int QBITS  = 33;   // quotient bits kept below the overflow bound
    localparam int NLANE  = 9;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [COF_W-1:0]  t_cof;
    typedef logic [3:0]               t_idx;

    // determinant status passed from the determinant stages to the divider
    typedef struct packed {
        logic              sing;
        logic              dneg;
        logic [DMAG_W-1:0] dmag;
    } t_det_info;

    // cofactor (r,c) = a[p]*a[q] - a[r]*a[s], flat row-major entry indexes
    localparam t_idx COF_IX [NLANE][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

endpackage

FILE: rtl/mi3_if.sv
// ----------------------------------------------------------------------------
// mi3_if
// Valid/ready channels: the input matrix and the inverse result.
// ----------------------------------------------------------------------------
interface mi3_in_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  a00, a01, a02, a10, a11, a12, a20, a21, a22;

    modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    input ready);
    modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    output ready);
endinterface

interface mi3_out_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  b00, b01, b02, b10, b11, b12, b20, b21, b22;
    logic                singular;

    modport source (output valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                    singular, input ready);
    modport sink   (input valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                    singular, output ready);
endinterface

FILE: rtl/mi3_cofactor.sv
// ----------------------------------------------------------------------------
// mi3_cofactor
// Two stages: eighteen 32x32 products, then the nine signed cofactors.
// ----------------------------------------------------------------------------
module mi3_cofactor (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  mi3_pkg::t_data  i_a [mi3_pkg::NLANE],
    output logic            o_valid,
    input  logic            i_ready,
    output mi3_pkg::t_cof   o_cof [mi3_pkg::NLANE],
    output mi3_pkg::t_data  o_row0 [3]
);
    import mi3_pkg::*;

    localparam int NST = 2;

    logic [NST-1:0]           r_vld;
    logic [NST:0]             w_rdy;
    logic signed [PROD_W-1:0] r_pp [NLANE];
    logic signed [PROD_W-1:0] r_pn [NLANE];
    t_data                    r_row0_s0 [3];
    t_data                    r_row0_s1 [3];
    t_cof                     r_cof [NLANE];

    assign w_rdy[NST] = i_ready;
    for (genvar k = 0; k < NST; k++) begin : g_rdy
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_valid;
            if (w_rdy[1]) r_vld[1] <= r_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            for (int l = 0; l < NLANE; l++) begin
                r_pp[l] <= i_a[COF_IX[l][0]] * i_a[COF_IX[l][1]];
                r_pn[l] <= i_a[COF_IX[l][2]] * i_a[COF_IX[l][3]];
            end
            for (int j = 0; j < 3; j++) r_row0_s0[j] <= i_a[j];
        end
        if (w_rdy[1]) begin
            for (int l = 0; l < NLANE; l++) begin
                r_cof[l] <= COF_W'(r_pp[l]) - COF_W'(r_pn[l]);
            end
            r_row0_s1 <= r_row0_s0;
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[NST-1];
    assign o_cof   = r_cof;
    assign o_row0  = r_row0_s1;

endmodule

FILE: rtl/mi3_det.sv
// ----------------------------------------------------------------------------
// mi3_det
// Five stages: first-row expansion of the determinant, exact.
// ----------------------------------------------------------------------------
module mi3_det (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mi3_pkg::t_cof      i_cof [mi3_pkg::NLANE],
    input  mi3_pkg::t_data     i_row0 [3],
    output logic               o_valid,
    input  logic               i_ready,
    output mi3_pkg::t_cof      o_cof [mi3_pkg::NLANE],
    output mi3_pkg::t_det_info o_info
);
    import mi3_pkg::*;

    localparam int NST = 5;

    logic [NST-1:0]          r_vld;
    logic [NST:0]            w_rdy;
    t_cof                    r_cofp [NST][NLANE];
    logic [CMAG_W-1:0]       r0_cmag [3];
    logic [DATA_W-1:0]       r0_emag [3];
    logic [2:0]              r0_tneg;
    logic [2*DATA_W-1:0]     r1_plo [3];
    logic [2*DATA_W-1:0]     r1_phi [3];
    logic [2:0]              r1_tneg;
    logic signed [DET_W-1:0] r2_term [3];
    logic signed [DET_W-1:0] r3_det;
    t_det_info               r4_info;
    logic signed [DET_W-1:0] w_dabs;

    assign w_rdy[NST] = i_ready;
    for (genvar k = 0; k < NST; k++) begin : g_rdy
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NST; k++) begin
                if (w_rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // cofactors ride along for the divider
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) r_cofp[0] <= i_cof;
        for (int k = 1; k < NST; k++) begin
            if (w_rdy[k]) r_cofp[k] <= r_cofp[k-1];
        end
    end

    assign w_dabs = r3_det[DET_W-1] ? -r3_det : r3_det;

    always_ff @(posedge i_clk) begin
        // sign and magnitude of each first-row term
        if (w_rdy[0]) begin
            for (int j = 0; j < 3; j++) begin
                r0_cmag[j] <= i_cof[j][COF_W-1] ? CMAG_W'(-i_cof[j]) : CMAG_W'(i_cof[j]);
                r0_emag[j] <= i_row0[j][DATA_W-1] ? DATA_W'(-i_row0[j])
                                                  : DATA_W'(i_row0[j]);
                r0_tneg[j] <= i_cof[j][COF_W-1] ^ i_row0[j][DATA_W-1];
            end
        end
        // 64x32 split into two 32x32 partial products
        if (w_rdy[1]) begin
            for (int j = 0; j < 3; j++) begin
                r1_plo[j] <= {32'd0, r0_cmag[j][31:0]} * {32'd0, r0_emag[j]};
                r1_phi[j] <= {32'd0, r0_cmag[j][63:32]} * {32'd0, r0_emag[j]};
            end
            r1_tneg <= r0_tneg;
        end
        if (w_rdy[2]) begin
            for (int j = 0; j < 3; j++) begin
                r2_term[j] <= r1_tneg[j]
                    ? -$signed({2'b00, r1_phi[j], 32'd0} + {34'd0, r1_plo[j]})
                    :  $signed({2'b00, r1_phi[j], 32'd0} + {34'd0, r1_plo[j]});
            end
        end
        if (w_rdy[3]) r3_det <= r2_term[0] + r2_term[1] + r2_term[2];
        if (w_rdy[4]) begin
            r4_info.sing <= (r3_det == '0);
            r4_info.dneg <= r3_det[DET_W-1];
            r4_info.dmag <= w_dabs[DMAG_W-1:0];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[NST-1];
    assign o_cof   = r_cofp[NST-1];
    assign o_info  = r4_info;

endmodule

FILE: rtl/mi3_div.sv
// ----------------------------------------------------------------------------
// mi3_div
// Nine-lane pipelined restoring divider: one quotient bit per stage,
// round half away from zero, saturate to 32 bits.
// ----------------------------------------------------------------------------
module mi3_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mi3_pkg::t_cof      i_cof [mi3_pkg::NLANE],
    input  mi3_pkg::t_det_info i_info,
    output logic               o_valid,
    input  logic               i_ready,
    output mi3_pkg::t_data     o_b [mi3_pkg::NLANE],
    output logic               o_singular
);
    import mi3_pkg::*;

    localparam int NUM_W = CMAG_W + 2*FRAC_BITS;
    localparam int REM_W = DMAG_W + QBITS;
    localparam int NST   = QBITS + 4;   // abs, init, QBITS steps, round, saturate
    localparam logic [QBITS:0] POS_MAX = (QBITS+1)'(32'h7FFF_FFFF);
    localparam logic [QBITS:0] NEG_MAX = (QBITS+1)'(32'h8000_0000);

    logic [NST-1:0]     r_vld;
    logic [NST:0]       w_rdy;

    // abs stage
    logic [CMAG_W-1:0]  r0_cmag [NLANE];
    logic [NLANE-1:0]   r0_cneg;
    t_det_info          r0_info;

    // step pipeline, index 0 is the init stage
    logic [REM_W-1:0]   r_rem  [QBITS+1][NLANE];
    logic [QBITS-1:0]   r_q    [QBITS+1][NLANE];
    logic [NLANE-1:0]   r_ovf  [QBITS+1];
    logic [NLANE-1:0]   r_neg  [QBITS+1];
    logic [DMAG_W-1:0]  r_d    [QBITS+1];
    logic               r_sing [QBITS+1];

    // round stage
    logic [QBITS:0]     r_mag [NLANE];
    logic [NLANE-1:0]   r_rovf;
    logic [NLANE-1:0]   r_rneg;
    logic               r_rsing;

    // output register
    t_data              r_b [NLANE];
    logic               r_osing;

    logic [NUM_W-1:0]   w_num [NLANE];

    assign w_rdy[NST] = i_ready;
    for (genvar k = 0; k < NST; k++) begin : g_rdy
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NST; k++) begin
                if (w_rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    for (genvar l = 0; l < NLANE; l++) begin : g_num
        assign w_num[l] = {r0_cmag[l], {(2*FRAC_BITS){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            for (int l = 0; l < NLANE; l++) begin
                r0_cmag[l] <= i_cof[l][COF_W-1] ? CMAG_W'(-i_cof[l]) : CMAG_W'(i_cof[l]);
                r0_cneg[l] <= i_cof[l][COF_W-1];
            end
            r0_info <= i_info;
        end
        // init: a quotient of 2^QBITS or more saturates whatever the sign
        if (w_rdy[1]) begin
            for (int l = 0; l < NLANE; l++) begin
                r_rem[0][l] <= {{(REM_W-NUM_W){1'b0}}, w_num[l]};
                r_q[0][l]   <= '0;
                r_ovf[0][l] <= {{(REM_W-NUM_W){1'b0}}, w_num[l]}
                               >= {r0_info.dmag, {QBITS{1'b0}}};
                r_neg[0][l] <= r0_cneg[l] ^ r0_info.dneg;
            end
            r_d[0]    <= r0_info.dmag;
            r_sing[0] <= r0_info.sing;
        end
    end

    for (genvar s = 1; s <= QBITS; s++) begin : g_step
        localparam int SH = QBITS - s;
        logic [REM_W-1:0] w_dsh;
        assign w_dsh = {{QBITS{1'b0}}, r_d[s-1]} << SH;

        always_ff @(posedge i_clk) begin
            if (w_rdy[s+1]) begin
                for (int l = 0; l < NLANE; l++) begin
                    if (r_rem[s-1][l] >= w_dsh) begin
                        r_rem[s][l] <= r_rem[s-1][l] - w_dsh;
                        r_q[s][l]   <= {r_q[s-1][l][QBITS-2:0], 1'b1};
                    end else begin
                        r_rem[s][l] <= r_rem[s-1][l];
                        r_q[s][l]   <= {r_q[s-1][l][QBITS-2:0], 1'b0};
                    end
                end
                r_ovf[s]  <= r_ovf[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_d[s]    <= r_d[s-1];
                r_sing[s] <= r_sing[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[QBITS+2]) begin
            for (int l = 0; l < NLANE; l++) begin
                // remainder is below the divisor here unless overflow was flagged
                r_mag[l] <= {1'b0, r_q[QBITS][l]}
                    + (QBITS+1)'({r_rem[QBITS][l][DMAG_W-1:0], 1'b0}
                                 >= {1'b0, r_d[QBITS]});
            end
            r_rovf  <= r_ovf[QBITS];
            r_rneg  <= r_neg[QBITS];
            r_rsing <= r_sing[QBITS];
        end
        if (w_rdy[QBITS+3]) begin
            for (int l = 0; l < NLANE; l++) begin
                if (r_rsing) begin
                    r_b[l] <= '0;
                end else if (!r_rneg[l]) begin
                    r_b[l] <= (r_rovf[l] || r_mag[l] > POS_MAX) ? 32'sh7FFF_FFFF
                                                                : t_data'(r_mag[l][31:0]);
                end else begin
                    r_b[l] <= (r_rovf[l] || r_mag[l] > NEG_MAX) ? t_data'(32'h8000_0000)
                                                                : t_data'(-r_mag[l][31:0]);
                end
            end
            r_osing <= r_rsing;
        end
    end

    assign o_ready    = w_rdy[0];
    assign o_valid    = r_vld[NST-1];
    assign o_b        = r_b;
    assign o_singular = r_osing;

endmodule

FILE: rtl/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Inverse of a signed fixed-point 3x3 matrix through the adjugate.
// ----------------------------------------------------------------------------
// Usage:
//   i_mat carries one matrix per beat (a00..a22, row-major, signed, FRAC_BITS
//   fraction bits). o_inv returns one inverse per beat (b00..b22 in the same
//   format, saturated to the 32-bit limits) and singular, set with all entries
//   zero when the determinant is exactly zero. Quotients round to nearest,
//   ties away from zero.
//   Throughput: one matrix per cycle while the receiver does not stall. From
//   acceptance to o_inv.valid: 2 cofactor stages, 5 determinant stages, 37
//   divider stages (one quotient bit per stage for 33 bits, plus abs, init,
//   round and saturate). The 33-stage bit-serial divide sets the latency.
//   Every stage has its own valid bit and moves when the next one is empty
//   or moving, so bubbles close up and a new matrix is taken while a result
//   waits at the output register. A receiver stall fills the pipe; once all
//   44 stages hold data i_mat.ready drops. Nothing is lost or repeated.
//   Reset (synchronous, active low) empties every stage; the block keeps no
//   other state and has no configuration.
// ----------------------------------------------------------------------------
module matrix3x3_inverse #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mi3_in_if.sink    i_mat,
    mi3_out_if.source o_inv
);
    import mi3_pkg::*;

    t_data      w_a [NLANE];
    t_cof       w_cof1 [NLANE];
    t_data      w_row0 [3];
    logic       w_v1, w_r1;
    t_cof       w_cof2 [NLANE];
    t_cof       w_cof_t [NLANE];
    t_det_info  w_info;
    logic       w_v2, w_r2;
    t_data      w_b [NLANE];

    assign w_a[0] = i_mat.a00;
    assign w_a[1] = i_mat.a01;
    assign w_a[2] = i_mat.a02;
    assign w_a[3] = i_mat.a10;
    assign w_a[4] = i_mat.a11;
    assign w_a[5] = i_mat.a12;
    assign w_a[6] = i_mat.a20;
    assign w_a[7] = i_mat.a21;
    assign w_a[8] = i_mat.a22;

    // products and 2x2 cofactors
    mi3_cofactor u_cof (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_mat.valid),
        .o_ready (i_mat.ready),
        .i_a     (w_a),
        .o_valid (w_v1),
        .i_ready (w_r1),
        .o_cof   (w_cof1),
        .o_row0  (w_row0)
    );

    // determinant along the first row
    mi3_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v1),
        .o_ready (w_r1),
        .i_cof   (w_cof1),
        .i_row0  (w_row0),
        .o_valid (w_v2),
        .i_ready (w_r2),
        .o_cof   (w_cof2),
        .o_info  (w_info)
    );

    // transpose: result (i,j) uses cofactor (j,i)
    for (genvar i = 0; i < 3; i++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            assign w_cof_t[i*3+j] = w_cof2[j*3+i];
        end
    end

    mi3_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_v2),
        .o_ready    (w_r2),
        .i_cof      (w_cof_t),
        .i_info     (w_info),
        .o_valid    (o_inv.valid),
        .i_ready    (o_inv.ready),
        .o_b        (w_b),
        .o_singular (o_inv.singular)
    );

    assign o_inv.b00 = w_b[0];
    assign o_inv.b01 = w_b[1];
    assign o_inv.b02 = w_b[2];
    assign o_inv.b10 = w_b[3];
    assign o_inv.b11 = w_b[4];
    assign o_inv.b12 = w_b[5];
    assign o_inv.b20 = w_b[6];
    assign o_inv.b21 = w_b[7];
    assign o_inv.b22 = w_b[8];

`ifndef NO_ASSERTIONS
    // a singular result carries an all-zero matrix
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_inv.valid && o_inv.singular |->
            w_b[0] == 0 && w_b[1] == 0 && w_b[2] == 0 && w_b[3] == 0 &&
            w_b[4] == 0 && w_b[5] == 0 && w_b[6] == 0 && w_b[7] == 0 &&
            w_b[8] == 0)
        else $error("singular result with nonzero entries");

    // input back-pressure only when the output side is stalled
    a_bp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_mat.ready |-> o_inv.valid && !o_inv.ready)
        else $error("input stalled while output drains");

    // reset empties the pipe: first edge after release sees no output
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> !o_inv.valid)
        else $error("output valid right after reset");
`endif

endmodule
